>>> hdl/pesp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesp_pkg
// Shared types and constants for the protobuf envelope summary parser.
// ----------------------------------------------------------------------------
package pesp_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65535;
    localparam int unsigned ACC_W           = 35;
    localparam int unsigned SKIP_W          = 17;

    // Wire types of a protobuf tag
    localparam logic [2:0] WT_VINT = 3'd0;
    localparam logic [2:0] WT_I64  = 3'd1;
    localparam logic [2:0] WT_LEN  = 3'd2;
    localparam logic [2:0] WT_I32  = 3'd5;

    localparam logic [31:0] FIELD_FRAME_ID    = 32'd1;
    localparam logic [31:0] FIELD_VARIANT_MIN = 32'd2;
    localparam logic [31:0] FIELD_VARIANT_MAX = 32'd17;

    localparam logic [SKIP_W-1:0] SKIP_I64 = SKIP_W'(8);
    localparam logic [SKIP_W-1:0] SKIP_I32 = SKIP_W'(4);

    localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [31:0] msg_id;
        logic [4:0]  sel_tag;
        logic [31:0] sel_value;
    } t_out_item;

endpackage

>>> hdl/protobuf_envelope_summary_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_envelope_summary_parser_core
// Decodes protobuf wire-format frames byte by byte and reports frame id,
// first variant tag and its value (or length) at end of frame.
// ----------------------------------------------------------------------------
// Throughput: one input transfer per cycle while no held-back summary stalls the
//   input; each byte is decoded by the shift-or, compare and counter logic ahead of the state regs.
// Output: the summary is in the output register in the cycle after the
//   end-of-frame transfer.
// Reset: synchronous, active low; clears parse state and the output valid.
module protobuf_envelope_summary_parser_core
    import pesp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [1:0] {
        PH_TAG,
        PH_VALUE,
        PH_LENGTH,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_SKIP,
        ROLE_FRAME,
        ROLE_VARIANT
    } t_role;

    t_phase              r_phase,   n_phase;
    logic [ACC_W-1:0]    r_acc,     n_acc;
    logic                r_upper,   n_upper;
    logic [3:0]          r_cnt,     n_cnt;
    t_role               r_role,    n_role;
    logic [SKIP_W-1:0]   r_skip,    n_skip;
    logic [31:0]         r_fid,     n_fid;
    logic [4:0]          r_tag,     n_tag;
    logic [31:0]         r_val,     n_val;
    logic                r_err,     n_err;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_data,  n_out_data;

    logic                w_accept;
    logic [ACC_W-1:0]    w_acc_or;
    logic                w_upper;
    logic [31:0]         w_field;
    logic [2:0]          w_wt;
    logic [3:0]          w_cnt_inc;
    logic                w_ok;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Merge this byte's seven payload bits into the varint
    always_comb begin
        unique case (r_cnt)
            4'd0: w_acc_or = r_acc | ACC_W'(i_in_data.data_byte[6:0]);
            4'd1: w_acc_or = r_acc | (ACC_W'(i_in_data.data_byte[6:0]) << 7);
            4'd2: w_acc_or = r_acc | (ACC_W'(i_in_data.data_byte[6:0]) << 14);
            4'd3: w_acc_or = r_acc | (ACC_W'(i_in_data.data_byte[6:0]) << 21);
            4'd4: w_acc_or = r_acc | (ACC_W'(i_in_data.data_byte[6:0]) << 28);
            default: w_acc_or = r_acc;
        endcase
        w_upper = r_upper
            || (r_cnt >= 4'd5 && r_cnt <= 4'd8 && (|i_in_data.data_byte[6:0]))
            || (r_cnt >= 4'd9 && i_in_data.data_byte[0]);
        w_field   = w_acc_or[34:3];
        w_wt      = w_acc_or[2:0];
        w_cnt_inc = r_cnt + 4'd1;
    end

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_upper     = r_upper;
        n_cnt       = r_cnt;
        n_role      = r_role;
        n_skip      = r_skip;
        n_fid       = r_fid;
        n_tag       = r_tag;
        n_val       = r_val;
        n_err       = r_err;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_out_stall;
        w_ok        = 1'b0;

        if (w_accept && i_in_data.has_byte && !r_err) begin
            if (r_phase == PH_SKIP) begin
                n_skip = r_skip - SKIP_W'(1);
                if (n_skip == '0) begin
                    n_phase = PH_TAG;
                end
            end else if (i_in_data.data_byte[7]) begin
                // Continuation: hold the partial varint
                n_acc   = w_acc_or;
                n_upper = w_upper;
                n_cnt   = w_cnt_inc;
                if (w_cnt_inc >= VARINT_MAX_BYTES) begin
                    n_err = 1'b1;
                end
            end else begin
                n_acc   = '0;
                n_upper = 1'b0;
                n_cnt   = '0;
                unique case (r_phase)
                    PH_TAG: begin
                        n_role = ROLE_SKIP;
                        if (w_field == FIELD_FRAME_ID && w_wt == WT_VINT) begin
                            n_role  = ROLE_FRAME;
                            n_phase = PH_VALUE;
                        end else if (w_field >= FIELD_VARIANT_MIN
                                     && w_field <= FIELD_VARIANT_MAX
                                     && r_tag == '0) begin
                            n_tag  = w_field[4:0];
                            n_role = ROLE_VARIANT;
                            if (w_wt == WT_VINT) begin
                                n_phase = PH_VALUE;
                            end else if (w_wt == WT_LEN) begin
                                n_phase = PH_LENGTH;
                            end else begin
                                n_err = 1'b1;
                            end
                        end else begin
                            unique case (w_wt)
                                WT_VINT: n_phase = PH_VALUE;
                                WT_I64: begin
                                    n_skip  = SKIP_I64;
                                    n_phase = PH_SKIP;
                                end
                                WT_LEN:    n_phase = PH_LENGTH;
                                WT_I32: begin
                                    n_skip  = SKIP_I32;
                                    n_phase = PH_SKIP;
                                end
                                default:   n_err = 1'b1;
                            endcase
                        end
                    end
                    PH_VALUE: begin
                        if (r_role == ROLE_FRAME) begin
                            n_fid = w_acc_or[31:0];
                        end else if (r_role == ROLE_VARIANT) begin
                            n_val = w_acc_or[31:0];
                        end
                        n_phase = PH_TAG;
                    end
                    default: begin
                        // Length prefix: reject oversized, else keep it for a variant and skip the payload
                        if (w_upper || w_acc_or > ACC_W'(MAX_FRAME_BYTES)) begin
                            n_err = 1'b1;
                        end else begin
                            if (r_role == ROLE_VARIANT) begin
                                n_val = w_acc_or[31:0];
                            end
                            if (w_acc_or[SKIP_W-1:0] == '0) begin
                                n_phase = PH_TAG;
                            end else begin
                                n_skip  = w_acc_or[SKIP_W-1:0];
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                endcase
            end
        end

        if (w_accept && i_in_data.end_of_frame) begin
            w_ok = !n_err && n_phase == PH_TAG && n_cnt == '0;
            n_out_valid          = 1'b1;
            n_out_data.ok        = w_ok;
            n_out_data.msg_id    = w_ok ? n_fid : '0;
            n_out_data.sel_tag   = w_ok ? n_tag : '0;
            n_out_data.sel_value = w_ok ? n_val : '0;
            // Drop all per-frame state
            n_phase = PH_TAG;
            n_acc   = '0;
            n_upper = 1'b0;
            n_cnt   = '0;
            n_role  = ROLE_SKIP;
            n_skip  = '0;
            n_fid   = '0;
            n_tag   = '0;
            n_val   = '0;
            n_err   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG;
            r_acc       <= '0;
            r_upper     <= 1'b0;
            r_cnt       <= '0;
            r_role      <= ROLE_SKIP;
            r_skip      <= '0;
            r_fid       <= '0;
            r_tag       <= '0;
            r_val       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_upper     <= n_upper;
            r_cnt       <= n_cnt;
            r_role      <= n_role;
            r_skip      <= n_skip;
            r_fid       <= n_fid;
            r_tag       <= n_tag;
            r_val       <= n_val;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

endmodule

>>> hdl/pesp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesp_checker
// Port-level checks for the protobuf envelope summary parser.
// ----------------------------------------------------------------------------
module pesp_checker
    import pesp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // A failed frame reports nothing else
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ok) |->
            (o_out_data.msg_id == '0 && o_out_data.sel_tag == '0
             && o_out_data.sel_value == '0))
        else $error("failed frame carries nonzero fields");

    a_tag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.sel_tag == 5'd0
             || (o_out_data.sel_tag >= 5'd2 && o_out_data.sel_tag <= 5'd17)))
        else $error("variant tag out of range");

    // Input stalls only while a finished summary is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked output");

    a_eof_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.end_of_frame) |=> o_out_valid)
        else $error("end of frame gave no summary");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output transfer changed");

endmodule

bind protobuf_envelope_summary_parser_core pesp_checker u_pesp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
